@@ src/npvl_pkg.sv @@
// shared types and constants for the nearest point value lookup
package npvl_pkg;

  localparam int OUT_VALUE_W = 32;
  localparam int OUT_INDEX_W = 10;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } sq_ctl_t;

endpackage

@@ src/npvl_sqacc.sv @@
// shared squared-difference unit with distance accumulator
module npvl_sqacc
  import npvl_pkg::*;
#(
  parameter int CW = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  sq_ctl_t             ctl,
  input  logic signed [CW-1:0] a,
  input  logic signed [CW-1:0] b,
  output logic                dist_valid,
  output logic [2*CW+1:0]     sq_dist
);

  localparam int DIST_W = 2 * CW + 2;

  logic [CW:0]       diff;
  logic [CW:0]       mag1;
  sq_ctl_t           ctl1;
  logic [DIST_W-1:0] sq2;
  sq_ctl_t           ctl2;
  logic [DIST_W-1:0] acc;
  logic [DIST_W-1:0] acc_sum;

  assign diff    = {a[CW-1], a} - {b[CW-1], b};
  assign acc_sum = (ctl2.first ? '0 : acc) + sq2;
  assign sq_dist = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1       <= '0;
      ctl2       <= '0;
      dist_valid <= 1'b0;
    end else begin
      ctl1       <= ctl;
      ctl2       <= ctl1;
      dist_valid <= ctl2.valid & ctl2.last;
    end
    mag1 <= diff[CW] ? (~diff + 1'b1) : diff;
    sq2  <= mag1 * mag1;
    if (ctl2.valid) begin
      acc <= acc_sum;
    end
  end

endmodule

@@ src/nearest_point_value_lookup.sv @@
// Nearest point value lookup: a table of up to MAX_POINTS points, each with x, y, z and a value.
// Clear, load and unused opcodes, and a query on an empty table, register their result when
// accepted. A query scans the stored points in 2D or 3D mode: one squaring unit is shared
// over the coordinates of every entry, one coordinate per cycle, while the table memory
// delivers each entry in step with its coordinates; the scan then drains the squaring
// pipeline and fetches the winning value. A new item is taken only when no query runs and no
// result waits, or when the waiting result leaves in the same cycle.
module nearest_point_value_lookup
  import npvl_pkg::*;
#(
  parameter int MAX_POINTS  = 1024,
  parameter int COORD_WIDTH = 24,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic signed [COORD_WIDTH-1:0] coord_z,
  input  logic signed [VALUE_WIDTH-1:0] point_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [OUT_VALUE_W-1:0] found_value,
  output logic [OUT_INDEX_W-1:0]        nearest_index,
  output logic [1:0]                    status
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIST_W = 2 * COORD_WIDTH + 2;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_SCAN,
    S_DRAIN,
    S_FETCH,
    S_RESULT
  } state_t;

  logic [COORD_WIDTH-1:0] table_x [MAX_POINTS];
  logic [COORD_WIDTH-1:0] table_y [MAX_POINTS];
  logic [COORD_WIDTH-1:0] table_z [MAX_POINTS];
  logic [VALUE_WIDTH-1:0] table_value [MAX_POINTS];

  state_t                 state;
  logic                   three_dim;
  logic                   dims3;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_m1;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       last_idx;
  logic [IDX_W-1:0]       cmp_idx;
  logic [IDX_W-1:0]       best_idx;
  logic [DIST_W-1:0]      best_dist;
  logic [1:0]             step;
  logic                   step_last;
  logic [COORD_WIDTH-1:0] qx;
  logic [COORD_WIDTH-1:0] qy;
  logic [COORD_WIDTH-1:0] qz;
  logic [IDX_W-1:0]       rd_addr;
  logic [COORD_WIDTH-1:0] rd_x;
  logic [COORD_WIDTH-1:0] rd_y;
  logic [COORD_WIDTH-1:0] rd_z;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic                   accept;
  logic                   out_free;
  logic                   do_write;
  logic [IDX_W-1:0]       wr_addr;
  sq_ctl_t                sq_ctl;
  logic [COORD_WIDTH-1:0] sq_a;
  logic [COORD_WIDTH-1:0] sq_b;
  logic                   dist_valid;
  logic [DIST_W-1:0]      sq_dist;
  logic [IDX_W+OUT_INDEX_W-1:0]       load_idx_ext;
  logic [IDX_W+OUT_INDEX_W-1:0]       best_idx_ext;
  logic [VALUE_WIDTH+OUT_VALUE_W-1:0] value_ext;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign count_m1  = count - 1'b1;
  assign wr_addr   = count[IDX_W-1:0];
  assign do_write  = accept && (opcode == OP_LOAD) && (count < MAX_CNT);
  assign step_last = dims3 ? (step == 2'd2) : (step == 2'd1);

  assign load_idx_ext = {{OUT_INDEX_W{1'b0}}, wr_addr};
  assign best_idx_ext = {{OUT_INDEX_W{1'b0}}, best_idx};
  assign value_ext    = {{OUT_VALUE_W{1'b0}}, rd_value};

  always_comb begin
    case (state)
      S_PRIME: rd_addr = '0;
      S_SCAN:  rd_addr = step_last ? idx + 1'b1 : idx;
      S_FETCH: rd_addr = best_idx;
      default: rd_addr = idx + 1'b1;
    endcase
  end

  always_comb begin
    sq_ctl.valid = (state == S_SCAN);
    sq_ctl.first = (step == 2'd0);
    sq_ctl.last  = step_last;
    case (step)
      2'd0:    begin sq_a = rd_x; sq_b = qx; end
      2'd1:    begin sq_a = rd_y; sq_b = qy; end
      default: begin sq_a = rd_z; sq_b = qz; end
    endcase
  end

  // table memories
  always_ff @(posedge clk) begin
    if (do_write) begin
      table_x[wr_addr]     <= coord_x;
      table_y[wr_addr]     <= coord_y;
      table_z[wr_addr]     <= coord_z;
      table_value[wr_addr] <= point_value;
    end
    rd_x     <= table_x[rd_addr];
    rd_y     <= table_y[rd_addr];
    rd_z     <= table_z[rd_addr];
    rd_value <= table_value[rd_addr];
  end

  npvl_sqacc #(
    .CW(COORD_WIDTH)
  ) u_sqacc (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sq_ctl),
    .a         (sq_a),
    .b         (sq_b),
    .dist_valid(dist_valid),
    .sq_dist   (sq_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      three_dim <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        three_dim <= cfg_wr_data;
      end
      if (out_valid && !out_stall && !accept) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            out_valid     <= (opcode != OP_QUERY) || (count == '0);
            found_value   <= '0;
            nearest_index <= '0;
            status        <= ST_DONE;
            case (opcode)
              OP_CLEAR: begin
                count <= '0;
              end
              OP_LOAD: begin
                if (count < MAX_CNT) begin
                  count         <= count + 1'b1;
                  nearest_index <= load_idx_ext[OUT_INDEX_W-1:0];
                end else begin
                  status <= ST_FULL;
                end
              end
              OP_QUERY: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  state <= S_PRIME;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PRIME: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (step_last) begin
            step <= 2'd0;
            idx  <= idx + 1'b1;
            if (idx == last_idx) begin
              state <= S_DRAIN;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DRAIN: begin
          if (dist_valid && (cmp_idx == last_idx)) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            found_value   <= value_ext[OUT_VALUE_W-1:0];
            nearest_index <= best_idx_ext[OUT_INDEX_W-1:0];
            status        <= ST_DONE;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    // query setup and running minimum
    if (accept) begin
      qx       <= coord_x;
      qy       <= coord_y;
      qz       <= coord_z;
      dims3    <= three_dim;
      idx      <= '0;
      step     <= 2'd0;
      cmp_idx  <= '0;
      last_idx <= count_m1[IDX_W-1:0];
    end
    if (dist_valid) begin
      cmp_idx <= cmp_idx + 1'b1;
      if ((cmp_idx == '0) || (sq_dist < best_dist)) begin
        best_dist <= sq_dist;
        best_idx  <= cmp_idx;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= MAX_CNT)
    else $error("entry count beyond table depth");

  a_dist_in_query: assert property (@(posedge clk) disable iff (rst)
    dist_valid |-> (state == S_SCAN || state == S_DRAIN))
    else $error("distance result outside a query");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_LOAD && count < MAX_CNT) |=> (count == $past(count) + 1'b1))
    else $error("load did not advance entry count");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_QUERY && count != '0) |=> (!out_valid && state == S_PRIME))
    else $error("query did not start a scan");

endmodule
